// File: src/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types, constants and helpers for the 9x9 backtracking solver.
// ----------------------------------------------------------------------------
package sbs_pkg;

    // Board geometry
    localparam int GRID_SIDE  = 9;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(GRID_CELLS);

    // Stream commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // One board entry: clue flag plus digit
    typedef struct packed {
        logic       fixed;
        logic [3:0] value;
    } t_cell;

    // Write request into the board store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_cell             data;
    } t_mem_wr;

    // Result transaction payload, read_value in the low bits
    typedef struct packed {
        logic       solved;
        logic [3:0] read_value;
    } t_result;

    // Row-major cell address: row * 9 + col
    function automatic logic [ADDR_W-1:0] f_cell_addr(input logic [3:0] row,
                                                      input logic [3:0] col);
        logic [7:0] sum;
        sum = {1'b0, row, 3'b000} + {4'b0000, row} + {4'b0000, col};
        return sum[ADDR_W-1:0];
    endfunction

    // First row or column of the 3x3 box holding the given index
    function automatic logic [3:0] f_box_base(input logic [3:0] idx);
        logic [3:0] base;
        if (idx < 4'd3) begin
            base = 4'd0;
        end else if (idx < 4'd6) begin
            base = 4'd3;
        end else begin
            base = 4'd6;
        end
        return base;
    endfunction

    // Offset within a box for scan step j (0..8): j / 3 and j % 3
    function automatic logic [3:0] f_div3(input logic [3:0] j);
        return (j < 4'd3) ? 4'd0 : ((j < 4'd6) ? 4'd1 : 4'd2);
    endfunction

    function automatic logic [3:0] f_mod3(input logic [3:0] j);
        return j - 4'd3 * f_div3(j);
    endfunction

    // Digit to one-hot mask, digit 1 at bit 0; empty gives no bit
    function automatic logic [GRID_SIDE-1:0] f_val_bit(input logic [3:0] v);
        logic [GRID_SIDE-1:0] m;
        m = '0;
        for (int k = 1; k <= GRID_SIDE; k++) begin
            if (v == 4'(k)) begin
                m[k-1] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// File: src/sbs_board_mem.sv
// ----------------------------------------------------------------------------
// sbs_board_mem
// Board store: 81 entries, one write and one registered read per cycle.
// Per-entry valid flags make unwritten entries read as empty after reset.
// ----------------------------------------------------------------------------
module sbs_board_mem
    import sbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_wr           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_cell             o_rd_data
);

    t_cell                 r_mem [GRID_CELLS];
    logic [GRID_CELLS-1:0] r_vld;
    t_cell                 r_rd_data;
    logic                  r_rd_vld;

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Valid flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: src/sudoku_backtracking_solver.sv
// Path: a write or unknown command goes straight to the result stage; a read first passes
// through the registered board read. Each result then moves into the output register.
// Solve: a clue-marking sweep over the board, then cell visits in search order; each
// empty-cell visit makes 27 neighbor reads through the single board read port.
// Input is not ready during a solve or a read, nor while a result waits in the result stage.
// Reset (sync, active low) empties the board and clears all control state.
// ----------------------------------------------------------------------------
// sudoku_backtracking_solver
// Loads a 9x9 board, runs a depth-first backtracking search on demand and
// reads cells back. Conflict checks reuse one scan unit over the board store.
// ----------------------------------------------------------------------------
module sudoku_backtracking_solver
    import sbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // command[1:0] row[5:2] column[9:6] cell_value[13:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // read_value[3:0] solved[4]
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RDATA = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_CELL  = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_LAST  = 3'd6;

    localparam logic [ADDR_W-1:0] CELLS_A = ADDR_W'(GRID_CELLS);
    localparam logic [3:0]        SIDE_M1 = 4'(GRID_SIDE - 1);

    // Control registers
    logic [2:0]  r_state, n_state;
    logic        r_pend_vld, n_pend_vld;
    logic        r_out_vld, n_out_vld;
    logic        r_acc_v, n_acc_v;

    // Payload and search registers
    t_result              r_pend, n_pend;
    t_result              r_out, n_out;
    logic                 r_rd_ok, n_rd_ok;
    logic [ADDR_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]    r_sw_addr, n_sw_addr;
    logic [ADDR_W-1:0]    r_pos, n_pos;
    logic [3:0]           r_row, n_row;
    logic [3:0]           r_col, n_col;
    logic                 r_fwd, n_fwd;
    logic [3:0]           r_old, n_old;
    logic [GRID_SIDE-1:0] r_used, n_used;
    logic                 r_self, n_self;
    logic [1:0]           r_grp, n_grp;
    logic [3:0]           r_j, n_j;

    // Board store interface
    t_mem_wr           mem_wr;
    logic [ADDR_W-1:0] rd_addr;
    t_cell             rd_data;

    // Input fields
    logic [1:0] in_cmd;
    logic [3:0] in_row, in_col, in_val;
    logic       in_grid, in_acc;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_row  = s_axis_tdata[5:2];
    assign in_col  = s_axis_tdata[9:6];
    assign in_val  = s_axis_tdata[13:10];
    assign in_grid = (in_row <= SIDE_M1) && (in_col <= SIDE_M1);
    assign s_axis_tready = (r_state == ST_IDLE) && !r_pend_vld;
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    sbs_board_mem u_board (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Scan address: row group, column group, then box group
    logic [3:0]        sc_row, sc_col;
    logic [ADDR_W-1:0] scan_addr;

    always_comb begin
        unique case (r_grp)
            2'd0: begin
                sc_row = r_row;
                sc_col = r_j;
            end
            2'd1: begin
                sc_row = r_j;
                sc_col = r_col;
            end
            default: begin
                sc_row = f_box_base(r_row) + f_div3(r_j);
                sc_col = f_box_base(r_col) + f_mod3(r_j);
            end
        endcase
        scan_addr = f_cell_addr(sc_row, sc_col);
    end

    // Neighbor mask including the last scan read, and the next candidate digit
    logic [GRID_SIDE-1:0] used_all;
    logic [3:0]           pick;
    logic                 pick_ok;

    always_comb begin
        used_all = r_used | (r_self ? '0 : f_val_bit(rd_data.value));
        pick     = '0;
        pick_ok  = 1'b0;
        for (int k = GRID_SIDE; k >= 1; k--) begin
            if (!used_all[k-1] && (4'(k) > r_old)) begin
                pick    = 4'(k);
                pick_ok = 1'b1;
            end
        end
    end

    // Neighbor cursor steps
    logic [ADDR_W-1:0] pos_inc, pos_dec;
    logic [3:0]        row_inc, col_inc, row_dec, col_dec;

    always_comb begin
        pos_inc = r_pos + 1'b1;
        pos_dec = r_pos - 1'b1;
        if (r_col == SIDE_M1) begin
            col_inc = '0;
            row_inc = r_row + 1'b1;
        end else begin
            col_inc = r_col + 1'b1;
            row_inc = r_row;
        end
        if (r_col == 4'd0) begin
            col_dec = SIDE_M1;
            row_dec = r_row - 1'b1;
        end else begin
            col_dec = r_col - 1'b1;
            row_dec = r_row;
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_acc_v    = r_acc_v;
        n_rd_ok    = r_rd_ok;
        n_cnt      = r_cnt;
        n_sw_addr  = r_sw_addr;
        n_pos      = r_pos;
        n_row      = r_row;
        n_col      = r_col;
        n_fwd      = r_fwd;
        n_old      = r_old;
        n_used     = r_used;
        n_self     = r_self;
        n_grp      = r_grp;
        n_j        = r_j;
        mem_wr     = '0;
        rd_addr    = r_pos;

        // Result stage into output register
        if (r_pend_vld && (!r_out_vld || m_axis_tready)) begin
            n_out      = r_pend;
            n_out_vld  = 1'b1;
            n_pend_vld = 1'b0;
        end else if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        CMD_WRITE: begin
                            if (in_grid && (in_val <= SIDE_M1 + 4'd1)) begin
                                mem_wr.en         = 1'b1;
                                mem_wr.addr       = f_cell_addr(in_row, in_col);
                                mem_wr.data.value = in_val;
                            end
                            n_pend_vld = 1'b1;
                            n_pend     = '0;
                        end
                        CMD_SOLVE: begin
                            n_cnt   = '0;
                            n_acc_v = 1'b0;
                            n_state = ST_SWEEP;
                        end
                        CMD_READ: begin
                            rd_addr = in_grid ? f_cell_addr(in_row, in_col) : '0;
                            n_rd_ok = in_grid;
                            n_state = ST_RDATA;
                        end
                        default: begin
                            n_pend_vld = 1'b1;
                            n_pend     = '0;
                        end
                    endcase
                end
            end

            ST_RDATA: begin
                n_pend_vld        = 1'b1;
                n_pend.solved     = 1'b0;
                n_pend.read_value = r_rd_ok ? rd_data.value : 4'd0;
                n_state           = ST_IDLE;
            end

            // Mark every nonempty cell as a clue, read one entry and write back the previous
            ST_SWEEP: begin
                if (r_acc_v) begin
                    mem_wr.en         = 1'b1;
                    mem_wr.addr       = r_sw_addr;
                    mem_wr.data.value = rd_data.value;
                    mem_wr.data.fixed = (rd_data.value != 4'd0);
                end
                if (r_cnt != CELLS_A) begin
                    rd_addr   = r_cnt;
                    n_sw_addr = r_cnt;
                    n_cnt     = r_cnt + 1'b1;
                    n_acc_v   = 1'b1;
                end else begin
                    n_acc_v = 1'b0;
                    n_pos   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_fwd   = 1'b1;
                    n_state = ST_CELL;
                end
            end

            ST_CELL: begin
                if (r_pos == CELLS_A) begin
                    n_pend_vld = 1'b1;
                    n_pend     = '{solved: 1'b1, read_value: 4'd0};
                    n_state    = ST_IDLE;
                end else begin
                    rd_addr = r_pos;
                    n_state = ST_CHK;
                end
            end

            // Clue cells are passed over in the current direction
            ST_CHK: begin
                if (rd_data.fixed) begin
                    if (r_fwd) begin
                        n_pos   = pos_inc;
                        n_row   = row_inc;
                        n_col   = col_inc;
                        n_state = ST_CELL;
                    end else if (r_pos == '0) begin
                        n_pend_vld = 1'b1;
                        n_pend     = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_pos   = pos_dec;
                        n_row   = row_dec;
                        n_col   = col_dec;
                        n_state = ST_CELL;
                    end
                end else begin
                    n_old   = rd_data.value;
                    n_used  = '0;
                    n_grp   = '0;
                    n_j     = '0;
                    n_acc_v = 1'b0;
                    n_state = ST_SCAN;
                end
            end

            // Read the 27 row, column and box neighbors; the cell itself counts as empty
            ST_SCAN: begin
                rd_addr = scan_addr;
                n_self  = (scan_addr == r_pos);
                n_acc_v = 1'b1;
                if (r_acc_v && !r_self) begin
                    n_used = r_used | f_val_bit(rd_data.value);
                end
                if (r_j == SIDE_M1) begin
                    n_j   = '0;
                    n_grp = r_grp + 1'b1;
                    if (r_grp == 2'd2) begin
                        n_state = ST_LAST;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end

            // Place the next free digit and advance, or clear and back up
            ST_LAST: begin
                n_acc_v     = 1'b0;
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_pos;
                if (pick_ok) begin
                    mem_wr.data.value = pick;
                    n_fwd   = 1'b1;
                    n_pos   = pos_inc;
                    n_row   = row_inc;
                    n_col   = col_inc;
                    n_state = ST_CELL;
                end else begin
                    n_fwd = 1'b0;
                    if (r_pos == '0) begin
                        n_pend_vld = 1'b1;
                        n_pend     = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_pos   = pos_dec;
                        n_row   = row_dec;
                        n_col   = col_dec;
                        n_state = ST_CELL;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_acc_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_acc_v    <= n_acc_v;
        end
    end

    // Payload and search datapath
    always_ff @(posedge i_clk) begin
        r_pend    <= n_pend;
        r_out     <= n_out;
        r_rd_ok   <= n_rd_ok;
        r_cnt     <= n_cnt;
        r_sw_addr <= n_sw_addr;
        r_pos     <= n_pos;
        r_row     <= n_row;
        r_col     <= n_col;
        r_fwd     <= n_fwd;
        r_old     <= n_old;
        r_used    <= n_used;
        r_self    <= n_self;
        r_grp     <= n_grp;
        r_j       <= n_j;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 9x9 backtracking solver. A short table of
// directed transactions is followed by random puzzles: each puzzle loads a
// valid grid with blanks and an occasional clash, then solves and reads back.
// Random noise is mixed in. Results are checked against an in-bench model of
// the board and its depth-first search; pinned rows against their own result.
// ----------------------------------------------------------------------------
module tb_top
    import sbs_pkg::*;
();

    localparam logic [1:0] CMD_NONE = 2'd3;      // unused opcode, no effect
    localparam int RAND_ITEMS   = 1880;
    localparam int SEARCH_LIMIT = 20000;          // cycles one search may take
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam t_result NO_RES  = '0;

    // One directed transaction; pinned rows carry their result literally
    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] row;
        logic [3:0] col;
        logic [3:0] val;
        logic       pinned;
        logic       solved;
        logic [3:0] rd;
    } t_vec;

    localparam int DIR_ROWS = 23;
    localparam t_vec DIR_TAB [DIR_ROWS] = '{
        '{CMD_READ,  4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 4'd0},   // empty after reset
        '{CMD_READ,  4'd8,  4'd8,  4'd0,  1'b1, 1'b0, 4'd0},
        '{CMD_WRITE, 4'd0,  4'd0,  4'd9,  1'b1, 1'b0, 4'd0},
        '{CMD_READ,  4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 4'd9},
        '{CMD_WRITE, 4'd8,  4'd8,  4'd1,  1'b1, 1'b0, 4'd0},
        '{CMD_READ,  4'd8,  4'd8,  4'd0,  1'b1, 1'b0, 4'd1},
        '{CMD_WRITE, 4'd15, 4'd0,  4'd5,  1'b1, 1'b0, 4'd0},   // row off the grid
        '{CMD_READ,  4'd15, 4'd0,  4'd0,  1'b1, 1'b0, 4'd0},
        '{CMD_WRITE, 4'd0,  4'd15, 4'd3,  1'b1, 1'b0, 4'd0},   // column off the grid
        '{CMD_READ,  4'd0,  4'd15, 4'd0,  1'b1, 1'b0, 4'd0},
        '{CMD_WRITE, 4'd4,  4'd4,  4'd15, 1'b1, 1'b0, 4'd0},   // digit too large
        '{CMD_READ,  4'd4,  4'd4,  4'd0,  1'b1, 1'b0, 4'd0},
        '{CMD_NONE,  4'd15, 4'd15, 4'd15, 1'b1, 1'b0, 4'd0},
        '{CMD_WRITE, 4'd4,  4'd4,  4'd5,  1'b1, 1'b0, 4'd0},
        '{CMD_READ,  4'd4,  4'd4,  4'd0,  1'b1, 1'b0, 4'd5},
        '{CMD_WRITE, 4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 4'd0},   // clear a cell
        '{CMD_READ,  4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 4'd0},
        '{CMD_SOLVE, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 4'd0},   // nearly empty board
        '{CMD_READ,  4'd0,  4'd1,  4'd0,  1'b0, 1'b0, 4'd0},
        '{CMD_READ,  4'd8,  4'd7,  4'd0,  1'b0, 1'b0, 4'd0},
        '{CMD_SOLVE, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 4'd0},   // solve again
        '{CMD_READ,  4'd4,  4'd4,  4'd0,  1'b1, 1'b0, 4'd5},   // clue survives
        '{CMD_NONE,  4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 4'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // command[1:0] row[5:2] column[9:6] cell_value[13:10]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // read_value[3:0] solved[4]

    // Board model and scratch copy used by the search
    logic [3:0] board_m    [GRID_CELLS];
    logic [3:0] trial_grid [GRID_CELLS];
    bit         trial_clue [GRID_CELLS];
    t_result    results_due [$];

    int idle_pct   = 0;
    int stall_pct  = 0;
    int fail_cnt   = 0;
    int items_sent = 0;
    bit hold_go    = 1'b0;
    bit hold_used  = 1'b0;
    int hold_left  = 0;

    sudoku_backtracking_solver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Digit k may go at (r, c) if no row, column or box neighbor holds it
    function automatic bit digit_fits(int r, int c, int k);
        int br;
        int bc;
        br = 3 * (r / 3);
        bc = 3 * (c / 3);
        for (int n = 0; n < GRID_SIDE; n++) begin
            if (trial_grid[r * GRID_SIDE + n] == 4'(k)) return 1'b0;
            if (trial_grid[n * GRID_SIDE + c] == 4'(k)) return 1'b0;
            if (trial_grid[(br + n / 3) * GRID_SIDE + bc + n % 3] == 4'(k)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Depth-first fill of trial_grid in row-major order, digits ascending.
    // Returns 1 when solved, 0 when exhausted (filled cells back to 0),
    // -1 when the search would run longer than the bench allows.
    function automatic int search_trial();
        int pos;
        int k;
        int cost;
        bit fwd;
        pos  = 0;
        fwd  = 1'b1;
        cost = 82;
        for (int n = 0; n < GRID_CELLS; n++) trial_clue[n] = (trial_grid[n] != 4'd0);
        while (pos < GRID_CELLS) begin
            if (cost > SEARCH_LIMIT) return -1;
            if (!trial_clue[pos]) begin
                cost += 30;
                k = int'(trial_grid[pos]) + 1;
                trial_grid[pos] = 4'd0;
                while (k <= GRID_SIDE && !digit_fits(pos / GRID_SIDE, pos % GRID_SIDE, k)) k++;
                if (k <= GRID_SIDE) begin
                    trial_grid[pos] = 4'(k);
                    fwd = 1'b1;
                end else begin
                    fwd = 1'b0;
                end
            end else begin
                cost += 2;
            end
            if (fwd) begin
                pos++;
            end else if (pos == 0) begin
                return 0;
            end else begin
                pos--;
            end
        end
        return 1;
    endfunction

    // Predict one transaction, queue its result, then hand it to the block
    task automatic offer(input logic [1:0] cmd, input logic [3:0] row, input logic [3:0] col,
                         input logic [3:0] val, input bit pinned, input t_result pinned_res);
        t_result want;
        int      verdict;
        int      idx;
        bit      on_board;
        verdict  = 0;
        on_board = (row < 4'd9) && (col < 4'd9);
        idx      = int'(row) * GRID_SIDE + int'(col);
        // a search too long for the run is swapped for a plain read
        if (cmd == CMD_SOLVE) begin
            for (int n = 0; n < GRID_CELLS; n++) trial_grid[n] = board_m[n];
            verdict = search_trial();
            if (verdict < 0) cmd = CMD_READ;
        end
        want = '0;
        case (cmd)
            CMD_WRITE: begin
                if (on_board && val <= 4'd9) board_m[idx] = val;
            end
            CMD_SOLVE: begin
                for (int n = 0; n < GRID_CELLS; n++) board_m[n] = trial_grid[n];
                want.solved = verdict[0];
            end
            CMD_READ: begin
                if (on_board) want.read_value = board_m[idx];
            end
            default: begin
            end
        endcase
        results_due.push_back(pinned ? pinned_res : want);

        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, val, col, row, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Random transaction of any kind, sometimes off the grid
    task automatic offer_noise();
        logic [3:0] row;
        logic [3:0] col;
        row = ($urandom_range(99) < 25) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        col = ($urandom_range(99) < 25) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        offer(2'($urandom_range(3)), row, col, 4'($urandom_range(15)), 1'b0, NO_RES);
    endtask

    // Load a relabeled valid grid with blanks, solve it and read some cells
    task automatic play_puzzle();
        logic [3:0] given [GRID_CELLS];
        int digit_map [9];
        int order [GRID_CELLS];
        int a, b, c, d;
        int rr, cm, j, t, pick, blanks;
        for (int i = 0; i < 9; i++) digit_map[i] = i + 1;
        for (int i = 8; i > 0; i--) begin
            j = $urandom_range(i);
            t = digit_map[i];
            digit_map[i] = digit_map[j];
            digit_map[j] = t;
        end
        a = $urandom_range(2);
        b = $urandom_range(2);
        c = $urandom_range(2);
        d = $urandom_range(2);
        pick = $urandom_range(99);
        if (pick < 10) begin
            blanks = 0;
        end else if (pick < 70) begin
            blanks = $urandom_range(25, 1);
        end else if (pick < 95) begin
            blanks = $urandom_range(45, 26);
        end else begin
            blanks = $urandom_range(60, 46);
        end
        // cyclic band and row shifts keep the base grid valid
        for (int r = 0; r < GRID_SIDE; r++) begin
            for (int col = 0; col < GRID_SIDE; col++) begin
                rr = 3 * ((r / 3 + a) % 3) + (r % 3 + b) % 3;
                cm = 3 * ((col / 3 + c) % 3) + (col % 3 + d) % 3;
                given[r * GRID_SIDE + col] = 4'(digit_map[(rr * 3 + rr / 3 + cm) % 9]);
                if ($urandom_range(80) < blanks) given[r * GRID_SIDE + col] = 4'd0;
            end
        end
        // occasional clashing clue
        if ($urandom_range(99) < 20) given[$urandom_range(80)] = 4'($urandom_range(9, 1));

        for (int i = 0; i < GRID_CELLS; i++) order[i] = i;
        for (int i = GRID_CELLS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < GRID_CELLS; i++) begin
            if ($urandom_range(99) < 4) offer_noise();
            offer(CMD_WRITE, 4'(order[i] / GRID_SIDE), 4'(order[i] % GRID_SIDE),
                  given[order[i]], 1'b0, NO_RES);
        end

        offer(CMD_SOLVE, 4'($urandom_range(15)), 4'($urandom_range(15)),
              4'($urandom_range(15)), 1'b0, NO_RES);
        repeat ($urandom_range(10, 3)) begin
            offer(CMD_READ, 4'($urandom_range(8)), 4'($urandom_range(8)), 4'd0, 1'b0, NO_RES);
        end
        if ($urandom_range(99) < 25) begin
            offer(CMD_SOLVE, 4'd0, 4'd0, 4'd0, 1'b0, NO_RES);
            repeat (2) begin
                offer(CMD_READ, 4'($urandom_range(8)), 4'($urandom_range(8)), 4'd0,
                      1'b0, NO_RES);
            end
        end
    endtask

    // Stimulus: reset, directed table, random phases, drain
    initial begin : stimulus
        t_result pin;
        int      target;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        for (int n = 0; n < GRID_CELLS; n++) board_m[n] = 4'd0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            pin.solved     = DIR_TAB[i].solved;
            pin.read_value = DIR_TAB[i].rd;
            offer(DIR_TAB[i].cmd, DIR_TAB[i].row, DIR_TAB[i].col, DIR_TAB[i].val,
                  DIR_TAB[i].pinned, pin);
        end

        // phases: free running, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 60 : ((ph == 3) ? 37 : 0);
            stall_pct = (ph == 2) ? 60 : ((ph == 3) ? 37 : 0);
            target    = DIR_ROWS + (ph + 1) * RAND_ITEMS / 4;
            if (ph == 0) begin
                // long receiver hold-off while the sender keeps pushing
                hold_go = 1'b1;
                repeat (40) offer_noise();
            end
            while (items_sent < target) begin
                if ($urandom_range(99) < 80) begin
                    play_puzzle();
                end else begin
                    repeat ($urandom_range(20, 10)) offer_noise();
                end
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        stall_pct     = 0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     = hold_left - 1;
            m_axis_tready = 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_used     = 1'b1;
            hold_left     = HOLD_CYCLES - 1;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[4:0];
            if (results_due.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("unexpected result: read_value=%0d solved=%0d",
                             got.read_value, got.solved);
                end
            end else begin
                want = results_due.pop_front();
                if (got.read_value !== want.read_value || got.solved !== want.solved) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("mismatch: expected read_value=%0d solved=%0d, got %0d %0d",
                                 want.read_value, want.solved, got.read_value, got.solved);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
